// ===== hdl/tmf_pkg.sv =====
// Shared types and constants for the two-queue FIFO matcher.
package tmf_pkg;

  localparam int ID_W     = 16;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 40;

  typedef enum logic [1:0] {
    OP_ADD_REQ = 2'd0,
    OP_ADD_SRV = 2'd1,
    OP_PAIR    = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

// ===== hdl/tmf_ram.sv =====
// Single-write, single-read queue memory with registered read data.
module tmf_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/two_queue_fifo_matcher.sv =====
// Top level of the two-queue FIFO matcher: requester and server queues with pair and cancel.
//
// The block holds two first-in first-out queues of 16-bit identifiers, one for requesters
// and one for servers, each QUEUE_DEPTH entries deep and kept as a circular buffer in its
// own memory with a head pointer and a fill count. Each input word carries an operation
// and an identifier: add requester, add server, pair the two heads, or cancel a requester
// id. Every input word produces exactly one output word. Adds and pairs run in two steps:
// the word is accepted, then, once the output register is free, the queue is updated and
// the result is loaded into the output register. A pair uses the head entries, which the
// memories read continuously while the block is idle. A cancel walks the requester queue
// one entry per cycle through the single read port of its memory, compares each entry
// against the id in one shared comparator, and writes the survivors back in order through
// the write port. The block takes one input word at a time; it may accept the next word
// while the previous result is still waiting to be taken on the output side, and it
// stalls only if a second result would overwrite it.
// An add to a full queue drops the id and sets overflow; a pair with an empty queue
// returns matched low with both ids zero. No clearing pass is needed after reset.
module two_queue_fifo_matcher #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [1:0] operation, [17:2] ident, [23:18] zero
  input  logic [tmf_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [0] matched, [16:1] server_id, [32:17] requester_id, [33] overflow, [39:34] zero
  output logic [tmf_pkg::OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  // Circular buffer address: base plus offset, wrapped once at the depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  tmf_pkg::state_t state, state_next;
  tmf_pkg::op_t    op;
  logic [tmf_pkg::ID_W-1:0] ident;

  logic [AW-1:0] r_head, s_head;
  logic [CW-1:0] r_count, s_count;
  logic [CW-1:0] scan_rd, scan_wr;
  logic          scan_v;

  logic                     matched, overflow;
  logic [tmf_pkg::ID_W-1:0] server_id, requester_id;

  logic                     r_we, s_we;
  logic [AW-1:0]            r_waddr, r_raddr;
  logic [tmf_pkg::ID_W-1:0] r_rdata, s_rdata;

  logic out_free, in_acc, exec_go, scan_done, keep, r_full, s_full, pair_ok;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == tmf_pkg::ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign exec_go   = (state == tmf_pkg::ST_EXEC) && out_free && (op != tmf_pkg::OP_CANCEL);
  assign scan_done = (state == tmf_pkg::ST_SCAN) && (scan_rd == r_count) && !scan_v;
  assign keep      = scan_v && (r_rdata != ident);
  assign r_full    = (r_count == FULL);
  assign s_full    = (s_count == FULL);
  assign pair_ok   = (r_count != '0) && (s_count != '0);

  // Requester memory: pushes at the tail, or compacting writes during a cancel scan.
  assign r_we    = (exec_go && op == tmf_pkg::OP_ADD_REQ && !r_full) ||
                   ((state == tmf_pkg::ST_SCAN) && keep);
  assign r_waddr = (state == tmf_pkg::ST_SCAN) ? wrap_add(r_head, scan_wr)
                                                : wrap_add(r_head, r_count);
  assign r_raddr = (state == tmf_pkg::ST_SCAN) ? wrap_add(r_head, scan_rd) : r_head;
  assign s_we    = exec_go && op == tmf_pkg::OP_ADD_SRV && !s_full;

  tmf_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW), .W(tmf_pkg::ID_W)) u_req_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata ((state == tmf_pkg::ST_SCAN) ? r_rdata : ident),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  tmf_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW), .W(tmf_pkg::ID_W)) u_srv_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (wrap_add(s_head, s_count)),
    .wdata (ident),
    .raddr (s_head),
    .rdata (s_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = tmf_pkg::ST_EXEC;
        end
      end
      tmf_pkg::ST_EXEC: begin
        if (op == tmf_pkg::OP_CANCEL) begin
          state_next = tmf_pkg::ST_SCAN;
        end else if (out_free) begin
          state_next = tmf_pkg::ST_IDLE;
        end
      end
      tmf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = tmf_pkg::ST_RESP;
        end
      end
      tmf_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = tmf_pkg::ST_IDLE;
        end
      end
      default: state_next = tmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured input word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op    <= tmf_pkg::op_t'(s_tdata[1:0]);
      ident <= s_tdata[17:2];
    end
  end

  // Queue pointers, fill counts and the cancel scan counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_head  <= '0;
      s_head  <= '0;
      r_count <= '0;
      s_count <= '0;
      scan_rd <= '0;
      scan_wr <= '0;
      scan_v  <= 1'b0;
    end else begin
      if (exec_go) begin
        case (op)
          tmf_pkg::OP_ADD_REQ: begin
            if (!r_full) r_count <= r_count + 1'b1;
          end
          tmf_pkg::OP_ADD_SRV: begin
            if (!s_full) s_count <= s_count + 1'b1;
          end
          tmf_pkg::OP_PAIR: begin
            if (pair_ok) begin
              r_head  <= wrap_add(r_head, CW'(1));
              s_head  <= wrap_add(s_head, CW'(1));
              r_count <= r_count - 1'b1;
              s_count <= s_count - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == tmf_pkg::ST_EXEC && op == tmf_pkg::OP_CANCEL) begin
        scan_rd <= '0;
        scan_wr <= '0;
        scan_v  <= 1'b0;
      end else if (state == tmf_pkg::ST_SCAN) begin
        if (scan_rd != r_count) begin
          scan_rd <= scan_rd + 1'b1;
          scan_v  <= 1'b1;
        end else begin
          scan_v  <= 1'b0;
        end
        if (keep) begin
          scan_wr <= scan_wr + 1'b1;
        end
        if (scan_done) begin
          r_count <= scan_wr;
        end
      end
    end
  end

  // Output register; a new result loads only when the previous one has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go || (state == tmf_pkg::ST_RESP && out_free)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      matched      <= (op == tmf_pkg::OP_PAIR) && pair_ok;
      server_id    <= ((op == tmf_pkg::OP_PAIR) && pair_ok) ? s_rdata : '0;
      requester_id <= ((op == tmf_pkg::OP_PAIR) && pair_ok) ? r_rdata : '0;
      overflow     <= ((op == tmf_pkg::OP_ADD_REQ) && r_full) ||
                      ((op == tmf_pkg::OP_ADD_SRV) && s_full);
    end else if (state == tmf_pkg::ST_RESP && out_free) begin
      matched      <= 1'b0;
      server_id    <= '0;
      requester_id <= '0;
      overflow     <= 1'b0;
    end
  end

  assign m_tdata = {6'b0, overflow, requester_id, server_id, matched};

endmodule

// ===== hdl/tmf_checker.sv =====
// Port-level checker for the two-queue FIFO matcher and its bind.
module tmf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [tmf_pkg::IN_W-1:0]  s_tdata,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [tmf_pkg::OUT_W-1:0] m_tdata
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // An unmatched result carries zero ids.
  a_zero_ids: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
    else $error("unmatched result with nonzero ids");

  // A pair and an overflow never come from the same word.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
    else $error("matched and overflow both set");

  // Only one input word is worked on at a time.
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind two_queue_fifo_matcher tmf_checker u_tmf_checker (.*);
